// ===== rtl/assr_pkg.sv =====
// ----------------------------------------------------------------------------
// assr_pkg: shared types and constants of the alpha synapse spike ring
// Kernel ROM functions, sequencer states and cell control bundle.
// ----------------------------------------------------------------------------
package assr_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned WeightW = 16;
  localparam int unsigned KernW   = 16;
  localparam int unsigned CurW    = 32;
  localparam int unsigned AccW    = 48;

  typedef enum logic [0:0] {
    CFG_INV_TAU      = 1'b0,
    CFG_PEAK_CURRENT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SCALE,
    ST_OUT
  } seq_state_t;

  // Control bundle broadcast from the sequencer to every cell.
  typedef struct packed {
    logic       shift;     // rotate the ring by one cell
    logic       load;      // write stamp/weight into the head cell
    logic [TimeW-1:0]   load_stamp;
    logic [WeightW-1:0] load_weight;
  } cell_ctrl_t;

  // Integer quotient by shift and subtract; elaboration only, small divisors
  function automatic logic [63:0] const_quot(input logic [63:0] num,
                                             input logic [63:0] den);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^t in Q30 by its power series, t in Q30
  function automatic logic [63:0] exp_series_q30(input logic [63:0] t);
    logic [63:0] sum, term;
    sum = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int n = 1; n < 48; n++) begin
      term = const_quot((term * t) >> 30, 64'(n));
      sum = sum + term;
    end
    return sum;
  endfunction

  // e*x*exp(-x) in Q1.15 for x = k*16/2^kshift; ratio steps the exponential
  // from one entry to the next, g0 is e in Q30. Evaluated at elaboration only.
  function automatic logic [15:0] kernel_value(input int unsigned k,
                                               input logic [63:0] ratio,
                                               input logic [63:0] g0,
                                               input int unsigned kshift);
    logic [63:0] g, v, num;
    g = g0;
    for (int unsigned j = 1; j <= k; j++) begin
      g = (g * ratio + (64'd1 << 29)) >> 30;
    end
    num = 64'd16 * 64'(k) * g;
    v = ((num >> kshift) + (64'd1 << 14)) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return v[15:0];
  endfunction

endpackage

// ===== rtl/assr_if.sv =====
// ----------------------------------------------------------------------------
// assr_in_if / assr_out_if: valid/ready channels of the spike ring
// One transaction per simulation tick in, one current per tick out.
// ----------------------------------------------------------------------------
interface assr_in_if;
  logic        valid;
  logic        ready;
  logic        connected;
  logic        spike_level;
  logic [31:0] now_time;
  logic signed [15:0] syn_weight;
  modport source (output valid, connected, spike_level, now_time, syn_weight,
                  input ready);
  modport sink   (input valid, connected, spike_level, now_time, syn_weight,
                  output ready);
endinterface

interface assr_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] synaptic_current;
  modport source (output valid, synaptic_current, input ready);
  modport sink   (input valid, synaptic_current, output ready);
endinterface

// ===== rtl/assr_cell.sv =====
// ----------------------------------------------------------------------------
// assr_cell: one spike slot of the ring
// Holds a stamp and weight; passes them to its neighbor on every shift.
// ----------------------------------------------------------------------------
module assr_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  assr_pkg::cell_ctrl_t ctrl,
  input  logic                head,
  input  logic [31:0]         prev_stamp,
  input  logic [15:0]         prev_weight,
  output logic [31:0]         stamp,
  output logic [15:0]         weight
);
  import assr_pkg::*;

  logic [TimeW-1:0]   stamp_r;
  logic [WeightW-1:0] weight_r;

  // slot store clears at reset; shift hands contents down the ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r  <= '0;
      weight_r <= '0;
    end else if (ctrl.shift) begin
      stamp_r  <= prev_stamp;
      weight_r <= prev_weight;
    end else if (ctrl.load && head) begin
      stamp_r  <= ctrl.load_stamp;
      weight_r <= ctrl.load_weight;
    end
  end

  assign stamp  = stamp_r;
  assign weight = weight_r;
endmodule

// ===== rtl/alpha_synapse_spike_ring_top.sv =====
// ----------------------------------------------------------------------------
// alpha_synapse_spike_ring_top: alpha-function synapse over a ring of slots
// Rotating cell ring, one kernel MAC per cycle, scaled saturated output.
// ----------------------------------------------------------------------------
// At the accepting edge the pointers move and the head slot is written.
// Then the cell ring rotates a full turn past the single kernel tap
// (ST_WALK), the tap pipeline (kernel index, registered ROM read,
// multiply-accumulate) drains and the sum is scaled by peak_current
// (ST_SCALE), and ST_OUT rounds, saturates and loads the output register.
// A disconnected tick goes from acceptance straight to ST_OUT and answers 0.
// The ring rotates one cell per cycle, so the physical slot at the tap
// advances with a rotation offset counter. A new tick is taken only once
// the previous result has left the output register.
// KERNEL_ENTRIES must be a power of two.
module alpha_synapse_spike_ring_top #(
  parameter int unsigned SPIKE_SLOTS    = 16,
  parameter int unsigned KERNEL_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  assr_in_if.sink     in_ch,
  assr_out_if.source  out_ch
);
  import assr_pkg::*;

  localparam int unsigned IdxW  = (SPIKE_SLOTS > 1) ? $clog2(SPIKE_SLOTS) : 1;
  localparam int unsigned KIdxW = $clog2(KERNEL_ENTRIES);
  localparam int unsigned CntW  = $clog2(SPIKE_SLOTS + 4);

  // kernel construction constants
  localparam logic [63:0] KernStep  = (64'd16 << 30) / KERNEL_ENTRIES;
  localparam logic [63:0] KernRatio = (64'd1 << 60) / exp_series_q30(KernStep);
  localparam logic [63:0] KernG0    = exp_series_q30(64'd1 << 30);

  // ---- configuration registers ----
  logic [15:0]        inv_tau_r;
  logic signed [15:0] peak_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_tau_r <= 16'd6554;
      peak_r    <= 16'sd256;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_INV_TAU:      inv_tau_r <= cfg_wdata;
        CFG_PEAK_CURRENT: peak_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- kernel ROM ----
  logic [15:0] kern_rom [KERNEL_ENTRIES];
  for (genvar k = 0; k < KERNEL_ENTRIES; k++) begin : g_rom
    assign kern_rom[k] = kernel_value(k, KernRatio, KernG0, KIdxW);
  end

  // ---- cell ring ----
  cell_ctrl_t  ctrl;
  logic [31:0] c_stamp  [SPIKE_SLOTS];
  logic [15:0] c_weight [SPIKE_SLOTS];
  logic [IdxW-1:0] rot_r, rot_nxt;   // physical slot currently in cell 0
  logic [IdxW-1:0] head_phys;
  logic [IdxW-1:0] head_off;         // cell that holds the head slot

  for (genvar c = 0; c < SPIKE_SLOTS; c++) begin : g_cell
    localparam int unsigned Prev = (c + 1) % SPIKE_SLOTS;
    logic head;
    // cell c holds physical slot rot+c
    assign head = (IdxW'(c) == head_off) ||
                  (SPIKE_SLOTS == 1);
    assr_cell u_cell (
      .clk, .rst_n, .ctrl, .head,
      .prev_stamp (c_stamp[Prev]),
      .prev_weight(c_weight[Prev]),
      .stamp      (c_stamp[c]),
      .weight     (c_weight[c])
    );
  end

  function automatic logic [IdxW-1:0] inc(input logic [IdxW-1:0] v);
    logic [IdxW:0] s;
    s = {1'b0, v} + 1'b1;
    if (s == (IdxW+1)'(SPIKE_SLOTS)) s = '0;
    return s[IdxW-1:0];
  endfunction

  // slot r lies in the window from o up to but not including w
  function automatic logic in_win(input logic [IdxW-1:0] r,
                                  input logic [IdxW-1:0] o,
                                  input logic [IdxW-1:0] w);
    if (o <= w) return (r >= o) && (r < w);
    return (r >= o) || (r < w);
  endfunction

  // ---- sequencer ----
  seq_state_t st_r, st_nxt;
  logic [IdxW-1:0] old_r, old_nxt, wr_r, wr_nxt;
  logic            prev_lvl_r, prev_lvl_nxt;
  logic [31:0]     now_r, now_nxt;
  logic            disc_r, disc_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            inside_r, inside_nxt;  // current tap slot lies in window
  logic            mac_v_r;
  logic            mac_in_r;
  logic            mac2_r;
  logic signed [AccW-1:0] acc_r, acc_nxt;
  logic signed [63:0] prod_r;
  logic signed [31:0] res_r;
  logic               res_v_r;
  logic               accept;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE) && !res_v_r;
  assign head_phys = wr_nxt;
  assign head_off  = (head_phys >= rot_r) ? (head_phys - rot_r) :
                     IdxW'(32'(head_phys) + SPIKE_SLOTS - 32'(rot_r));

  // tap stage 1: kernel index from cell 0
  logic [31:0] dt;
  logic [47:0] xq;
  logic [KIdxW-1:0] kidx_r;
  logic             kok_r;
  logic [15:0]      w_r;
  logic [15:0]      kval_r;
  logic [15:0]      w2_r;
  logic [47+KIdxW:0] sc;
  assign dt = now_r - c_stamp[0];
  assign xq = dt * inv_tau_r;
  assign sc = {xq, {KIdxW{1'b0}}} >> 20;

  always_comb begin
    st_nxt = st_r; old_nxt = old_r; wr_nxt = wr_r; prev_lvl_nxt = prev_lvl_r;
    now_nxt = now_r; disc_nxt = disc_r; cnt_nxt = cnt_r; rot_nxt = rot_r;
    inside_nxt = inside_r;
    ctrl = '0;
    ctrl.load_stamp  = in_ch.now_time;
    ctrl.load_weight = in_ch.syn_weight;
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          now_nxt  = in_ch.now_time;
          disc_nxt = !in_ch.connected;
          if (!in_ch.connected) begin
            old_nxt = '0; wr_nxt = '0;
            st_nxt = ST_OUT;
          end else begin
            if (in_ch.spike_level && !prev_lvl_r) begin
              wr_nxt = inc(wr_r);
              if (inc(wr_r) == old_r) old_nxt = inc(old_r);
            end
            ctrl.load = in_ch.spike_level;
            prev_lvl_nxt = in_ch.spike_level;
            cnt_nxt = '0;
            inside_nxt = in_win(rot_r, old_nxt, wr_nxt);
            st_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        ctrl.shift = 1'b1;
        rot_nxt = inc(rot_r);
        if (inc(rot_r) == wr_r) inside_nxt = 1'b0;
        else if (inc(rot_r) == old_r) inside_nxt = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntW'(SPIKE_SLOTS - 1)) st_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntW'(SPIKE_SLOTS + 2)) st_nxt = ST_OUT;
      end
      ST_OUT: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; old_r <= '0; wr_r <= '0; prev_lvl_r <= 1'b0;
      rot_r <= '0; cnt_r <= '0; inside_r <= 1'b0; disc_r <= 1'b0;
      mac_v_r <= 1'b0; mac_in_r <= 1'b0; mac2_r <= 1'b0;
    end else begin
      st_r <= st_nxt; old_r <= old_nxt; wr_r <= wr_nxt;
      prev_lvl_r <= prev_lvl_nxt; rot_r <= rot_nxt; cnt_r <= cnt_nxt;
      inside_r <= inside_nxt; disc_r <= disc_nxt;
      mac_v_r <= (st_r == ST_WALK);
      mac_in_r <= inside_r;
      mac2_r <= mac_v_r && kok_r && mac_in_r;
    end
  end

  always_ff @(posedge clk) begin
    now_r <= now_nxt;
  end

  // kernel index register, registered ROM read, then weight * kernel MAC
  logic signed [31:0] kw;
  assign kw = $signed(w2_r) * $signed({1'b0, kval_r[14:0]});
  always_ff @(posedge clk) begin
    kidx_r <= sc[KIdxW-1:0];
    kok_r  <= (sc[47+KIdxW:KIdxW] == '0) && inside_r;
    w_r    <= c_weight[0];
    kval_r <= kern_rom[kidx_r];
    w2_r   <= w_r;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (st_r == ST_IDLE) acc_nxt = '0;
    else if (mac2_r) acc_nxt = acc_r + AccW'(kw);
  end
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // scale, round half up, saturate
  logic signed [63:0] rnd;
  always_ff @(posedge clk) begin
    prod_r <= 64'(acc_r) * 64'(peak_r);
  end
  assign rnd = (prod_r + 64'sd262144) >>> 19;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (st_r == ST_OUT) begin
      res_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_v_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (st_r == ST_OUT) begin
      if (disc_r) res_r <= '0;
      else if (rnd > 64'sd2147483647) res_r <= 32'sh7fffffff;
      else if (rnd < -64'sd2147483648) res_r <= 32'sh80000000;
      else res_r <= rnd[31:0];
    end
  end

  assign out_ch.valid = res_v_r;
  assign out_ch.synaptic_current = res_r;

  // ---- assertions ----
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> !in_ch.ready) else $error("accept while busy");
  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_IDLE |-> cnt_r == '0 || cnt_r == CntW'(SPIKE_SLOTS + 3) ||
    cnt_r == CntW'(SPIKE_SLOTS)) else $error("walk count off");
  a_disc_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_ch.connected |=> old_r == '0 && wr_r == '0)
    else $error("pointers not cleared");
endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the alpha synapse spike ring
// Drives simulation ticks with random idling on both channels and predicts
// every synaptic current from a bit-exact ring and kernel model.
// It walks several inv_tau / peak_current settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
  import assr_pkg::*;

  localparam int unsigned RING  = 16;
  localparam int unsigned KROWS = 1024;

  // Ring state, kernel table and queue of predicted currents
  class synapse_scoreboard;
    int          kern_rom[KROWS];
    bit [31:0]   stamp[RING];
    logic signed [15:0] weight[RING];
    bit [3:0]    head_ptr, tail_ptr;
    bit          last_level;
    bit [15:0]   inv_tau;
    logic signed [15:0] peak;
    int          current_q[$];
    int          errors;

    // e^t in Q30 by its power series
    function bit [63:0] exp_q30(bit [63:0] t);
      bit [63:0] s, term;
      s = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int n = 1; n < 48; n++) begin
        term = ((term * t) >> 30) / n;
        s += term;
      end
      return s;
    endfunction

    function new();
      bit [63:0] step_ratio, g, v;
      step_ratio = (64'd1 << 60) / exp_q30((64'd16 << 30) / KROWS);
      g = exp_q30(64'd1 << 30);
      for (int k = 0; k < KROWS; k++) begin
        if (k > 0) g = (g * step_ratio + (64'd1 << 29)) >> 30;
        v = ((64'd16 * k * g) / KROWS + (64'd1 << 14)) >> 15;
        kern_rom[k] = (v > 64'd32767) ? 32767 : int'(v);
      end
      foreach (stamp[i]) begin
        stamp[i] = '0;
        weight[i] = '0;
      end
      head_ptr = '0;
      tail_ptr = '0;
      last_level = 1'b0;
      inv_tau = 16'd6554;
      peak = 16'sd256;
      errors = 0;
    endfunction

    function longint alpha_at(bit [31:0] dt);
      bit [63:0] x, row;
      x = 64'(dt) * 64'(inv_tau);
      row = x >> 10;
      if (row >= KROWS) return 0;
      return kern_rom[row];
    endfunction

    // Update the ring for one accepted tick and queue its current
    function void note_tick(bit conn, bit lvl, bit [31:0] now, logic signed [15:0] w);
      longint acc, v;
      bit [3:0] i;
      if (!conn) begin
        tail_ptr = '0;
        head_ptr = '0;
        current_q.push_back(0);
        return;
      end
      if (lvl) begin
        if (!last_level) begin
          head_ptr++;
          if (head_ptr == tail_ptr) tail_ptr++;
        end
        stamp[head_ptr] = now;
        weight[head_ptr] = w;
      end
      last_level = lvl;
      acc = 0;
      i = tail_ptr;
      while (i != head_ptr) begin
        acc += longint'(weight[i]) * alpha_at(now - stamp[i]);
        i++;
      end
      v = (acc * longint'(peak) + (64'sd1 <<< 18)) >>> 19;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      current_q.push_back(int'(v));
    endfunction

    function void check_current(int got);
      int want;
      if (current_q.size() == 0) begin
        $error("synaptic_current: unexpected result %0d", got);
        errors++;
        return;
      end
      want = current_q.pop_front();
      if (want != got) begin
        $error("synaptic_current: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [15:0] cfg_wdata;

  assr_in_if  in_ch();
  assr_out_if out_ch();

  alpha_synapse_spike_ring_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  synapse_scoreboard sb;
  bit          calm;
  bit [31:0]   tick_time;
  bit          spike_on;
  int unsigned ticks_sent;
  int unsigned currents_seen;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, checked at the rising edge
  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= (pick_gap() == 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_current(out_ch.synaptic_current);
      currents_seen++;
    end
  end

  // Offer one tick and wait for its transaction
  task automatic send_tick(bit conn, bit lvl, bit [31:0] now, logic signed [15:0] w);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.connected = conn;
    in_ch.spike_level = lvl;
    in_ch.now_time = now;
    in_ch.syn_weight = w;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_tick(conn, lvl, now, w);
    ticks_sent++;
  endtask

  // Let everything drain, then a quiet margin
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.current_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, bit [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_INV_TAU) sb.inv_tau = val;
    else sb.peak = val;
  endtask

  // Spike trains with random weights over a mostly advancing clock
  task automatic random_ticks(int unsigned n);
    int unsigned r;
    bit conn;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 80) tick_time += $urandom_range(1, 12);
      else if (r < 92) tick_time += $urandom_range(20, 200);
      else if (r < 96) tick_time -= $urandom_range(1, 30);
      else tick_time = $urandom();
      if ($urandom_range(0, 99) < 40) spike_on = ~spike_on;
      conn = ($urandom_range(0, 99) >= 3);
      send_tick(conn, spike_on, tick_time, 16'($urandom()));
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.connected = 1'b0;
    in_ch.spike_level = 1'b0;
    in_ch.now_time = '0;
    in_ch.syn_weight = '0;
    out_ch.ready = 1'b0;
    sb = new();
    ticks_sent = 0;
    currents_seen = 0;
    calm = 1'b0;
    spike_on = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: disconnect, weight extremes, time wrap, stamps in the future
    send_tick(1'b0, 1'b1, 32'd5, 16'sd100);
    send_tick(1'b1, 1'b1, 32'd0, 16'sh7fff);
    send_tick(1'b1, 1'b0, 32'd3, 16'sh8000);
    send_tick(1'b1, 1'b1, 32'd6, 16'sh8000);
    send_tick(1'b1, 1'b1, 32'd7, 16'sh7fff);
    send_tick(1'b1, 1'b0, 32'd20, 16'sd0);
    send_tick(1'b1, 1'b1, 32'hffff_fffe, 16'sh7fff);
    send_tick(1'b1, 1'b0, 32'hffff_ffff, 16'sd0);
    send_tick(1'b1, 1'b1, 32'd4, 16'sd4096);
    send_tick(1'b1, 1'b0, 32'd200, 16'sd0);
    send_tick(1'b1, 1'b1, 32'd100, 16'sh8000);
    send_tick(1'b1, 1'b0, 32'd2000, 16'sd0);
    send_tick(1'b0, 1'b0, 32'd2001, 16'sd0);
    send_tick(1'b1, 1'b1, 32'd2002, 16'sd1);
    send_tick(1'b1, 1'b0, 32'd2003, 16'sd0);
    tick_time = 32'd2003;
    random_ticks(300);
    drain();

    // Extremes: fastest decay with largest gain, slowest with most negative
    write_reg(CFG_INV_TAU, 16'hffff);
    write_reg(CFG_PEAK_CURRENT, 16'h7fff);
    random_ticks(300);
    drain();
    write_reg(CFG_INV_TAU, 16'd1);
    write_reg(CFG_PEAK_CURRENT, 16'h8000);
    random_ticks(300);
    drain();
    write_reg(CFG_INV_TAU, 16'd900);
    write_reg(CFG_PEAK_CURRENT, 16'hffff);
    random_ticks(300);
    drain();
    write_reg(CFG_INV_TAU, 16'($urandom_range(1, 65535)));
    write_reg(CFG_PEAK_CURRENT, 16'($urandom()));
    random_ticks(400);
    drain();

    $display("tb: %0d ticks sent, %0d currents checked over five register settings",
             ticks_sent, currents_seen);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/assr_pkg.sv
rtl/assr_if.sv
rtl/assr_cell.sv
rtl/alpha_synapse_spike_ring_top.sv
verif/tb.sv
